// ===== design/scp_pkg.sv =====
// ----------------------------------------------------------------------------
// Setpoint command line parser package
// Shared types, register indexes and default values for the parser block.
// ----------------------------------------------------------------------------
package scp_pkg;

  // Widths fixed by the field definitions
  localparam int unsigned CharW   = 8;
  localparam int unsigned RegW    = 20;
  localparam int unsigned MagW    = 11;
  localparam int unsigned CfgIdxW = 3;

  // Default structural parameters
  localparam int unsigned LineCharsDef     = 16;
  localparam int unsigned PanFieldCharsDef = 4;

  // Register reset values
  localparam logic [RegW-1:0] PanOffsetRst  = 20'd0;
  localparam logic [RegW-1:0] TiltOffsetRst = 20'd0;
  localparam logic [RegW-1:0] PanUpperRst   = 20'd389120;
  localparam logic [RegW-1:0] PanLowerRst   = 20'd102400;
  localparam logic [RegW-1:0] TiltUpperRst  = 20'd430080;
  localparam logic [RegW-1:0] TiltLowerRst  = 20'd204800;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PAN_OFFSET  = 3'd0,
    REG_TILT_OFFSET = 3'd1,
    REG_PAN_UPPER   = 3'd2,
    REG_PAN_LOWER   = 3'd3,
    REG_TILT_UPPER  = 3'd4,
    REG_TILT_LOWER  = 3'd5
  } cfg_reg_e;

  // Character codes
  localparam logic [CharW-1:0] ChCr    = 8'd13;
  localparam logic [CharW-1:0] ChLf    = 8'd10;
  localparam logic [CharW-1:0] ChSpace = 8'd32;
  localparam logic [CharW-1:0] ChTab   = 8'd9;
  localparam logic [CharW-1:0] ChVtab  = 8'd11;
  localparam logic [CharW-1:0] ChFf    = 8'd12;
  localparam logic [CharW-1:0] ChPlus  = 8'd43;
  localparam logic [CharW-1:0] ChMinus = 8'd45;
  localparam logic [CharW-1:0] ChZero  = 8'd48;
  localparam logic [CharW-1:0] ChNine  = 8'd57;
  localparam logic [CharW-1:0] ChTilt  = 8'd116;
  localparam logic [CharW-1:0] ChNul   = 8'd0;

  // Parse phase of the current line
  typedef enum logic [2:0] {
    PH_PAN_TAG     = 3'd0,
    PH_PAN_LEAD    = 3'd1,
    PH_PAN_DIGITS  = 3'd2,
    PH_PAN_REST    = 3'd3,
    PH_TAG_CHECK   = 3'd4,
    PH_TILT_LEAD   = 3'd5,
    PH_TILT_DIGITS = 3'd6,
    PH_IDLE        = 3'd7
  } phase_e;

  // Parsed numbers of the current line, handed to the target stage
  typedef struct packed {
    logic [MagW-1:0] pan_mag;
    logic            pan_minus;
    logic [MagW-1:0] tilt_mag;
    logic            tilt_minus;
    logic            tilt_seen;
  } line_t;

endpackage

// ===== design/scp_char_parser.sv =====
// ----------------------------------------------------------------------------
// Character parser
// Walks one command line a character at a time and accumulates the pan and
// tilt numbers with atoi rules and a saturating magnitude.
// ----------------------------------------------------------------------------
module scp_char_parser #(
  parameter int unsigned LINE_CHARS      = scp_pkg::LineCharsDef,
  parameter int unsigned PAN_FIELD_CHARS = scp_pkg::PanFieldCharsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,   // consume a non-terminator character
  input  logic                       clear_i,  // terminator consumed, start a new line
  input  logic [scp_pkg::CharW-1:0]  char_i,
  output scp_pkg::line_t             line_o
);
  import scp_pkg::*;

  localparam int unsigned LenW   = $clog2(LINE_CHARS);
  localparam int unsigned LenMax = LINE_CHARS - 1;
  localparam int unsigned ProdW  = MagW + 4;

  // Result of feeding one character into a number
  typedef struct packed {
    logic            lead;
    logic            digits;
    logic [MagW-1:0] mag;
    logic            minus;
  } feed_t;

  phase_e          phase_q, phase_d;
  logic [LenW-1:0] len_q, len_d;
  line_t           line_q, line_d;

  logic            room;
  logic            is_digit;
  logic            is_blank;
  logic            in_lead;
  logic [MagW-1:0] mag_sel;
  logic            minus_sel;
  logic [ProdW-1:0] mag_next;
  feed_t           feed;
  logic            pan_end;

  // Character classes and the number currently being read
  always_comb begin
    room      = (32'(len_q) < 32'(LenMax));
    is_digit  = (char_i >= ChZero) && (char_i <= ChNine);
    is_blank  = (char_i == ChSpace) || (char_i == ChTab) ||
                (char_i == ChVtab) || (char_i == ChFf);
    in_lead   = (phase_q == PH_PAN_LEAD) || (phase_q == PH_TILT_LEAD);
    pan_end   = (32'(len_q) >= 32'(PAN_FIELD_CHARS)) || (char_i == ChSpace);
    if (phase_q inside {PH_TILT_LEAD, PH_TILT_DIGITS}) begin
      mag_sel   = line_q.tilt_mag;
      minus_sel = line_q.tilt_minus;
    end else begin
      mag_sel   = line_q.pan_mag;
      minus_sel = line_q.pan_minus;
    end
    mag_next = ProdW'(mag_sel) * ProdW'(10) + ProdW'(char_i - ChZero);
  end

  // One character into the selected number
  always_comb begin
    feed.lead   = 1'b0;
    feed.digits = 1'b0;
    feed.mag    = mag_sel;
    feed.minus  = minus_sel;
    if (is_digit) begin
      feed.digits = 1'b1;
      feed.mag    = (mag_next > ProdW'({MagW{1'b1}})) ? {MagW{1'b1}} : mag_next[MagW-1:0];
    end else if (in_lead) begin
      if (is_blank) begin
        feed.lead = 1'b1;
      end else if (char_i == ChPlus) begin
        feed.digits = 1'b1;
      end else if (char_i == ChMinus) begin
        feed.digits = 1'b1;
        feed.minus  = 1'b1;
      end
    end
  end

  // Next parse phase and line length
  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    if (clear_i) begin
      phase_d = PH_PAN_TAG;
      len_d   = '0;
    end else if (step_i && room) begin
      len_d = len_q + LenW'(1);
      if (char_i == ChNul) begin
        phase_d = PH_IDLE;
      end else begin
        case (phase_q)
          PH_PAN_TAG: begin
            phase_d = (char_i == ChSpace) ? PH_TAG_CHECK : PH_PAN_LEAD;
          end
          PH_PAN_LEAD, PH_PAN_DIGITS, PH_PAN_REST: begin
            if (pan_end) begin
              phase_d = PH_TAG_CHECK;
            end else if (phase_q != PH_PAN_REST) begin
              phase_d = feed.lead ? PH_PAN_LEAD : feed.digits ? PH_PAN_DIGITS : PH_PAN_REST;
            end
          end
          PH_TAG_CHECK: begin
            phase_d = (char_i == ChTilt) ? PH_TILT_LEAD : PH_IDLE;
          end
          PH_TILT_LEAD, PH_TILT_DIGITS: begin
            phase_d = feed.lead ? PH_TILT_LEAD : feed.digits ? PH_TILT_DIGITS : PH_IDLE;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Number and tag updates
  always_comb begin
    line_d = line_q;
    if (clear_i) begin
      line_d = '0;
    end else if (step_i && room && (char_i != ChNul)) begin
      case (phase_q)
        PH_PAN_LEAD, PH_PAN_DIGITS: begin
          if (!pan_end) begin
            line_d.pan_mag   = feed.mag;
            line_d.pan_minus = feed.minus;
          end
        end
        PH_TAG_CHECK: begin
          if (char_i == ChTilt) begin
            line_d.tilt_seen = 1'b1;
          end
        end
        PH_TILT_LEAD, PH_TILT_DIGITS: begin
          line_d.tilt_mag   = feed.mag;
          line_d.tilt_minus = feed.minus;
        end
        default: begin
          line_d = line_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PAN_TAG;
      len_q   <= '0;
      line_q  <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      line_q  <= line_d;
    end
  end

  assign line_o = line_q;

endmodule

// ===== design/scp_target_calc.sv =====
// ----------------------------------------------------------------------------
// Target calculation
// Scales a parsed magnitude to 1/2048 degree, applies sign and offset and
// clamps the sum to the upper limit and then to the lower limit.
// ----------------------------------------------------------------------------
module scp_target_calc (
  input  logic [scp_pkg::MagW-1:0] mag_i,
  input  logic                     minus_i,
  input  logic [scp_pkg::RegW-1:0] base_i,
  input  logic [scp_pkg::RegW-1:0] upper_i,
  input  logic [scp_pkg::RegW-1:0] lower_i,
  output logic [scp_pkg::RegW-1:0] target_o
);
  import scp_pkg::*;

  localparam int unsigned SumW = MagW + 11 + 3;

  logic signed [SumW-1:0] scaled;
  logic signed [SumW-1:0] sum;
  logic signed [SumW-1:0] upper_s;
  logic signed [SumW-1:0] lower_s;

  // Signed sum of offset and scaled number, then the two clamps in order
  always_comb begin
    scaled  = $signed({3'b000, mag_i, 11'd0});
    upper_s = $signed(SumW'(upper_i));
    lower_s = $signed(SumW'(lower_i));
    sum     = minus_i ? ($signed(SumW'(base_i)) - scaled) : ($signed(SumW'(base_i)) + scaled);
    if (sum > upper_s) begin
      sum = upper_s;
    end
    if (sum < lower_s) begin
      sum = lower_s;
    end
    target_o = sum[RegW-1:0];
  end

endmodule

// ===== design/setpoint_command_line_parser.sv =====
// ----------------------------------------------------------------------------
// Setpoint command line parser
// Builds "p<int> t<int>" command lines from received bytes and emits the
// clamped pan and tilt targets when a CR or LF ends the line.
// ----------------------------------------------------------------------------
// A terminator byte raises the result's tvalid through the input register and then
// the result register. Throughput: one byte per cycle, limited only by the output
// side holding a result that is not yet taken.
// Reset clears the line, the held tilt and the registers to their defaults.
module setpoint_command_line_parser #(
  parameter int unsigned LINE_CHARS      = scp_pkg::LineCharsDef,
  parameter int unsigned PAN_FIELD_CHARS = scp_pkg::PanFieldCharsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] rx_byte
  // Result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [39:0]                  m_axis_tdata,   // [19:0] pan_target, [39:20] tilt_target
  output logic                         m_axis_tuser,   // [0] tilt_given
  // Configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [scp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [scp_pkg::RegW-1:0]     cfg_data_i
);
  import scp_pkg::*;

  logic             in_valid_q, in_valid_d;
  logic [CharW-1:0] in_char_q;
  logic             is_term;
  logic             consume;
  logic             step;
  logic             clear;

  logic [RegW-1:0]  pan_offset_q, tilt_offset_q;
  logic [RegW-1:0]  pan_upper_q, pan_lower_q, tilt_upper_q, tilt_lower_q;
  logic [RegW-1:0]  held_tilt_q;
  logic             held_valid_q;

  logic             out_valid_q, out_valid_d;
  logic [RegW-1:0]  out_pan_q, out_tilt_q;
  logic             out_given_q;

  line_t            line;
  logic [RegW-1:0]  pan_tgt;
  logic [RegW-1:0]  tilt_tgt;
  logic [MagW-1:0]  tilt_mag_sel;
  logic             tilt_minus_sel;
  logic [RegW-1:0]  tilt_base;

  // Handshake: a terminator waits only when the result register is blocked
  always_comb begin
    is_term       = (in_char_q == ChCr) || (in_char_q == ChLf);
    consume       = in_valid_q && (!is_term || !out_valid_q || m_axis_tready);
    step          = consume && !is_term;
    clear         = consume && is_term;
    s_axis_tready = !in_valid_q || consume;
    in_valid_d    = s_axis_tvalid || (in_valid_q && !consume);
    out_valid_d   = clear || (out_valid_q && !m_axis_tready);
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata;
    end
  end

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_offset_q  <= PanOffsetRst;
      tilt_offset_q <= TiltOffsetRst;
      pan_upper_q   <= PanUpperRst;
      pan_lower_q   <= PanLowerRst;
      tilt_upper_q  <= TiltUpperRst;
      tilt_lower_q  <= TiltLowerRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PAN_OFFSET:  pan_offset_q  <= cfg_data_i;
        REG_TILT_OFFSET: tilt_offset_q <= cfg_data_i;
        REG_PAN_UPPER:   pan_upper_q   <= cfg_data_i;
        REG_PAN_LOWER:   pan_lower_q   <= cfg_data_i;
        REG_TILT_UPPER:  tilt_upper_q  <= cfg_data_i;
        REG_TILT_LOWER:  tilt_lower_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Line parser
  scp_char_parser #(
    .LINE_CHARS      (LINE_CHARS),
    .PAN_FIELD_CHARS (PAN_FIELD_CHARS)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .clear_i (clear),
    .char_i  (in_char_q),
    .line_o  (line)
  );

  // Pan target
  scp_target_calc u_pan_calc (
    .mag_i    (line.pan_mag),
    .minus_i  (line.pan_minus),
    .base_i   (pan_offset_q),
    .upper_i  (pan_upper_q),
    .lower_i  (pan_lower_q),
    .target_o (pan_tgt)
  );

  // Tilt target: a held value is clamped as a zero number on that base
  always_comb begin
    if (line.tilt_seen) begin
      tilt_mag_sel   = line.tilt_mag;
      tilt_minus_sel = line.tilt_minus;
      tilt_base      = tilt_offset_q;
    end else begin
      tilt_mag_sel   = '0;
      tilt_minus_sel = 1'b0;
      tilt_base      = held_valid_q ? held_tilt_q : tilt_offset_q;
    end
  end

  scp_target_calc u_tilt_calc (
    .mag_i    (tilt_mag_sel),
    .minus_i  (tilt_minus_sel),
    .base_i   (tilt_base),
    .upper_i  (tilt_upper_q),
    .lower_i  (tilt_lower_q),
    .target_o (tilt_tgt)
  );

  // Held tilt and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_tilt_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (clear) begin
        held_valid_q <= 1'b1;
        held_tilt_q  <= tilt_tgt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear) begin
      out_pan_q   <= pan_tgt;
      out_tilt_q  <= tilt_tgt;
      out_given_q <= line.tilt_seen;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_tilt_q, out_pan_q};
  assign m_axis_tuser  = out_given_q;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Setpoint command line parser testbench
// Streams command line bytes into the parser and checks every pan and tilt
// setpoint that comes out against a cycle-free software copy of the parser.
// Runs a short directed set of lines and then random lines under several
// limit and offset settings and several sender and receiver stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import scp_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned StallCycles   = 400;
  localparam int unsigned DrainCycles   = 6;
  localparam int unsigned ItemsPerPhase = 200;
  localparam logic [CharW-1:0] ChP      = 8'h70;

  // State of the number being read in the software copy of the parser
  typedef enum logic [1:0] {
    NS_LEAD,
    NS_DIGITS,
    NS_END
  } num_state_e;

  // One expected setpoint pair
  typedef struct {
    logic [RegW-1:0] pan;
    logic [RegW-1:0] tilt;
    logic            given;
  } setpoint_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [39:0]        m_axis_tdata;
  logic               m_axis_tuser;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i   = '0;
  logic [RegW-1:0]    cfg_data_i    = '0;

  // Bytes waiting to be offered, and setpoints waiting to be seen
  logic [CharW-1:0] rx_backlog[$];
  logic [CharW-1:0] line_bytes[$];
  setpoint_t        expected_setpoints[$];

  // Copy of the register file and of the parser state
  logic [RegW-1:0] setpoint_regs [6];
  int unsigned     line_len       = 0;
  phase_e          parse_ph       = PH_PAN_TAG;
  logic [MagW-1:0] pan_mag        = '0;
  logic            pan_neg        = 1'b0;
  logic [MagW-1:0] tilt_mag       = '0;
  logic            tilt_neg       = 1'b0;
  logic            tilt_seen      = 1'b0;
  logic [RegW-1:0] held_tilt      = '0;
  logic            held_valid     = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          stall_armed   = 1'b0;
  int unsigned holdoff_done  = 0;
  int unsigned idle_cycles   = 0;
  int unsigned bytes_sent    = 0;
  int unsigned lines_checked = 0;
  int unsigned errors        = 0;

  setpoint_command_line_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock with a period of 4 ns.
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // One character into an atoi-style number; the magnitude saturates.
  function automatic num_state_e accumulate_digit(input logic [CharW-1:0] ch,
                                                  input bit lead,
                                                  inout logic [MagW-1:0] mag,
                                                  inout logic neg);
    int unsigned acc;
    if (ch >= ChZero && ch <= ChNine) begin
      acc = mag * 10 + (ch - ChZero);
      mag = (acc > 2047) ? 11'd2047 : acc[MagW-1:0];
      return NS_DIGITS;
    end
    if (lead) begin
      if (ch == ChSpace || ch == ChTab || ch == ChVtab || ch == ChFf) return NS_LEAD;
      if (ch == ChPlus) return NS_DIGITS;
      if (ch == ChMinus) begin
        neg = 1'b1;
        return NS_DIGITS;
      end
    end
    return NS_END;
  endfunction

  // Scale to 1/2048 degree, add the boot offset, clamp high then low.
  function automatic logic [RegW-1:0] scaled_setpoint(input logic [MagW-1:0] mag,
                                                      input logic neg,
                                                      input logic [RegW-1:0] offset,
                                                      input logic [RegW-1:0] upper,
                                                      input logic [RegW-1:0] lower);
    int v;
    v = int'(mag) * 2048;
    if (neg) v = -v;
    v = v + int'(offset);
    if (v > int'(upper)) v = int'(upper);
    if (v < int'(lower)) v = int'(lower);
    return v[RegW-1:0];
  endfunction

  // Advance the parser copy by one accepted byte; a terminator queues a setpoint.
  function automatic void advance_parser(input logic [CharW-1:0] ch);
    int unsigned pos;
    num_state_e  ns;
    setpoint_t   sp;
    logic [RegW-1:0] keep;
    if (ch == ChCr || ch == ChLf) begin
      sp.pan = scaled_setpoint(pan_mag, pan_neg, setpoint_regs[REG_PAN_OFFSET],
                               setpoint_regs[REG_PAN_UPPER], setpoint_regs[REG_PAN_LOWER]);
      if (tilt_seen) begin
        sp.tilt = scaled_setpoint(tilt_mag, tilt_neg, setpoint_regs[REG_TILT_OFFSET],
                                  setpoint_regs[REG_TILT_UPPER],
                                  setpoint_regs[REG_TILT_LOWER]);
      end else begin
        keep = held_valid ? held_tilt : setpoint_regs[REG_TILT_OFFSET];
        if (keep > setpoint_regs[REG_TILT_UPPER]) keep = setpoint_regs[REG_TILT_UPPER];
        if (keep < setpoint_regs[REG_TILT_LOWER]) keep = setpoint_regs[REG_TILT_LOWER];
        sp.tilt = keep;
      end
      sp.given   = tilt_seen;
      held_tilt  = sp.tilt;
      held_valid = 1'b1;
      expected_setpoints.push_back(sp);
      line_len  = 0;
      parse_ph  = PH_PAN_TAG;
      pan_mag   = '0;
      pan_neg   = 1'b0;
      tilt_mag  = '0;
      tilt_neg  = 1'b0;
      tilt_seen = 1'b0;
      return;
    end
    // Characters past the line buffer are dropped.
    if (line_len >= LineCharsDef - 1) return;
    pos = line_len;
    line_len++;
    // A zero byte ends the parsable text.
    if (ch == ChNul) begin
      parse_ph = PH_IDLE;
      return;
    end
    case (parse_ph)
      PH_PAN_TAG: begin
        parse_ph = (ch == ChSpace) ? PH_TAG_CHECK : PH_PAN_LEAD;
      end
      PH_PAN_LEAD, PH_PAN_DIGITS, PH_PAN_REST: begin
        if (pos >= PanFieldCharsDef || ch == ChSpace) begin
          parse_ph = PH_TAG_CHECK;
        end else if (parse_ph != PH_PAN_REST) begin
          ns = accumulate_digit(ch, parse_ph == PH_PAN_LEAD, pan_mag, pan_neg);
          parse_ph = (ns == NS_LEAD) ? PH_PAN_LEAD :
                     (ns == NS_DIGITS) ? PH_PAN_DIGITS : PH_PAN_REST;
        end
      end
      PH_TAG_CHECK: begin
        if (ch == ChTilt) begin
          tilt_seen = 1'b1;
          parse_ph  = PH_TILT_LEAD;
        end else begin
          parse_ph = PH_IDLE;
        end
      end
      PH_TILT_LEAD, PH_TILT_DIGITS: begin
        ns = accumulate_digit(ch, parse_ph == PH_TILT_LEAD, tilt_mag, tilt_neg);
        parse_ph = (ns == NS_LEAD) ? PH_TILT_LEAD :
                   (ns == NS_DIGITS) ? PH_TILT_DIGITS : PH_IDLE;
      end
      default: begin
        parse_ph = PH_IDLE;
      end
    endcase
  endfunction

  // Byte driver: predicts each byte on its transfer, then offers the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        advance_parser(s_axis_tdata);
        bytes_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (rx_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= rx_backlog.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Setpoint monitor: checks each transfer against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    setpoint_t sp;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_setpoints.size() == 0) begin
          $error("unexpected setpoint: pan_target %0d tilt_target %0d tilt_given %0d",
                 m_axis_tdata[19:0], m_axis_tdata[39:20], m_axis_tuser);
          errors++;
        end else begin
          sp = expected_setpoints.pop_front();
          if (m_axis_tdata[19:0] !== sp.pan) begin
            $error("pan_target: expected %0d, actual %0d", sp.pan, m_axis_tdata[19:0]);
            errors++;
          end
          if (m_axis_tdata[39:20] !== sp.tilt) begin
            $error("tilt_target: expected %0d, actual %0d", sp.tilt, m_axis_tdata[39:20]);
            errors++;
          end
          if (m_axis_tuser !== sp.given) begin
            $error("tilt_given: expected %0d, actual %0d", sp.given, m_axis_tuser);
            errors++;
          end
          lines_checked++;
        end
      end
      // A long hold-off once armed, otherwise random stalls.
      if (stall_armed && holdoff_done < StallCycles) begin
        holdoff_done++;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [RegW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    setpoint_regs[idx] = value;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(input logic [RegW-1:0] pan_off, input logic [RegW-1:0] tilt_off,
                           input logic [RegW-1:0] pan_hi, input logic [RegW-1:0] pan_lo,
                           input logic [RegW-1:0] tilt_hi, input logic [RegW-1:0] tilt_lo);
    write_reg(REG_PAN_OFFSET, pan_off);
    write_reg(REG_TILT_OFFSET, tilt_off);
    write_reg(REG_PAN_UPPER, pan_hi);
    write_reg(REG_PAN_LOWER, pan_lo);
    write_reg(REG_TILT_UPPER, tilt_hi);
    write_reg(REG_TILT_LOWER, tilt_lo);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    @(negedge clk_i);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Wait until every byte is taken and every setpoint seen, then let the
  // pipeline settle, since a byte with no result may still be in flight.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (rx_backlog.size() != 0 || s_axis_tvalid || expected_setpoints.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) rx_backlog.push_back(s[i]);
  endtask

  // Optional blanks, optional sign and a run of digits.
  task automatic append_number(input int unsigned max_digits);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        case ($urandom_range(0, 3))
          0:       line_bytes.push_back(ChSpace);
          1:       line_bytes.push_back(ChTab);
          2:       line_bytes.push_back(ChVtab);
          default: line_bytes.push_back(ChFf);
        endcase
      end
    end
    case ($urandom_range(0, 3))
      0:       line_bytes.push_back(ChPlus);
      1:       line_bytes.push_back(ChMinus);
      default: ;
    endcase
    repeat ($urandom_range(0, max_digits)) line_bytes.push_back(8'(ChZero + $urandom_range(0, 9)));
  endtask

  // Mostly well-formed command lines with random numbers, some mutated, some noise.
  task automatic queue_random_line(output int unsigned n);
    line_bytes.delete();
    if ($urandom_range(0, 99) < 10) begin
      repeat ($urandom_range(1, 24)) line_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      line_bytes.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : ChP);
      append_number(4);
      if ($urandom_range(0, 9) != 0) line_bytes.push_back(ChSpace);
      if ($urandom_range(0, 9) < 8) line_bytes.push_back(ChTilt);
      append_number(6);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) line_bytes.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) == 0) begin
        line_bytes[$urandom_range(0, line_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      end
    end
    case ($urandom_range(0, 2))
      0: line_bytes.push_back(ChCr);
      1: line_bytes.push_back(ChLf);
      default: begin
        line_bytes.push_back(ChCr);
        line_bytes.push_back(ChLf);
      end
    endcase
    n = line_bytes.size();
    foreach (line_bytes[i]) rx_backlog.push_back(line_bytes[i]);
  endtask

  task automatic queue_random_bytes(input int unsigned count);
    int unsigned total;
    int unsigned n;
    total = 0;
    @(negedge clk_i);
    while (total < count) begin
      queue_random_line(n);
      total += n;
    end
  endtask

  // Test sequence
  initial begin : sequencer
    logic [RegW-1:0] hi;
    setpoint_regs[REG_PAN_OFFSET]  = PanOffsetRst;
    setpoint_regs[REG_TILT_OFFSET] = TiltOffsetRst;
    setpoint_regs[REG_PAN_UPPER]   = PanUpperRst;
    setpoint_regs[REG_PAN_LOWER]   = PanLowerRst;
    setpoint_regs[REG_TILT_UPPER]  = TiltUpperRst;
    setpoint_regs[REG_TILT_LOWER]  = TiltLowerRst;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed lines under the reset limits.
    set_idling(27, 75);
    queue_text("p-2047 t-2047");
    rx_backlog.push_back(ChCr);
    rx_backlog.push_back(ChLf);
    queue_text("p+99 t+9999");
    rx_backlog.push_back(ChLf);
    queue_text("p");
    rx_backlog.push_back(ChLf);
    queue_text(" t12");
    rx_backlog.push_back(ChLf);
    queue_text("p12");
    rx_backlog.push_back(ChCr);
    queue_text("p1 x5");
    rx_backlog.push_back(ChCr);
    queue_text("p12345678 t9999999");
    rx_backlog.push_back(ChLf);
    queue_text("p1");
    rx_backlog.push_back(ChNul);
    queue_text(" t5");
    rx_backlog.push_back(ChLf);
    rx_backlog.push_back(ChP);
    rx_backlog.push_back(ChTab);
    queue_text("-5 t");
    rx_backlog.push_back(ChVtab);
    rx_backlog.push_back(ChFf);
    queue_text("+3");
    rx_backlog.push_back(ChLf);
    queue_text("p--3 t-+4");
    rx_backlog.push_back(ChCr);
    wait_drained();

    // Full range limits with a mid offset, then zero offsets.
    write_all(20'd368640, 20'd368640, 20'd737280, 20'd0, 20'd737280, 20'd0);
    queue_random_bytes(ItemsPerPhase);
    wait_drained();
    write_all(20'd0, 20'd0, 20'd737280, 20'd0, 20'd737280, 20'd0);
    queue_random_bytes(ItemsPerPhase);
    wait_drained();

    // Receiver mostly ready: largest offsets, then crossed limits.
    set_idling(75, 27);
    write_all(20'd737280, 20'd737280, 20'd737280, 20'd0, 20'd737280, 20'd0);
    queue_random_bytes(ItemsPerPhase);
    wait_drained();
    hi = 20'($urandom_range(0, 300000));
    write_all(20'($urandom_range(0, 737280)), 20'($urandom_range(0, 737280)),
              hi, 20'($urandom_range(hi + 1, 737280)),
              hi, 20'($urandom_range(hi + 1, 737280)));
    queue_random_bytes(ItemsPerPhase);
    wait_drained();

    // No idling: random settings with one long output stall, then all zero.
    set_idling(0, 0);
    write_all(20'($urandom_range(0, 737280)), 20'($urandom_range(0, 737280)),
              20'($urandom_range(0, 737280)), 20'($urandom_range(0, 737280)),
              20'($urandom_range(0, 737280)), 20'($urandom_range(0, 737280)));
    queue_random_bytes(ItemsPerPhase);
    stall_armed = 1'b1;
    wait_drained();
    write_all(20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0);
    queue_random_bytes(ItemsPerPhase);
    wait_drained();

    repeat (DrainCycles) @(posedge clk_i);
    $display("Checked %0d command lines built from %0d bytes over seven limit settings,",
             lines_checked, bytes_sent);
    $display("with stalls on both sides and one long hold-off of the setpoint output.");
    if (errors == 0 && expected_setpoints.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== setpoint_command_line_parser.f =====
design/scp_pkg.sv
design/scp_char_parser.sv
design/scp_target_calc.sv
design/setpoint_command_line_parser.sv
tb/tb_top.sv
